[rtl/arm_pkg.sv]
// ----------------------------------------------------------------------------
// arm_pkg: shared types and constants for the autorange resistance meter
// Holds field widths, register indexes and the divider request and answer structs.
// ----------------------------------------------------------------------------
package arm_pkg;

	localparam int SampleW = 24;
	localparam int RefW    = 32;
	localparam int ResW    = 33;

	localparam logic [SampleW-1:0] FullScale = 24'h7fffff;

	// register indexes
	localparam logic [2:0] RegRefCount = 3'd0;
	localparam logic [2:0] RegRef0     = 3'd1;
	localparam logic [2:0] RegRef1     = 3'd2;
	localparam logic [2:0] RegRef2     = 3'd3;
	localparam logic [2:0] RegRef3     = 3'd4;

	// request to the serial divider
	typedef struct packed {
		logic        start;
		logic [63:0] num;
		logic [31:0] den;
	} div_req_t;

	// answer from the serial divider
	typedef struct packed {
		logic        done;
		logic [63:0] quo;
	} div_rsp_t;

endpackage

[rtl/arm_div.sv]
// ----------------------------------------------------------------------------
// arm_div: bit-serial unsigned divider
// Restoring division, one quotient bit per cycle, 64-bit dividend.
// ----------------------------------------------------------------------------
module arm_div (
	input  logic              clk,
	input  logic              arst_n,
	input  arm_pkg::div_req_t req,
	output arm_pkg::div_rsp_t rsp
);

	logic [63:0] quo_q;
	logic [32:0] rem_q;
	logic [31:0] den_q;
	logic [6:0]  cnt_q;
	logic        busy_q;
	logic        done_q;
	logic [32:0] rem_sh;
	logic [33:0] diff;

	// shift in the next dividend bit and trial subtract
	always_comb begin
		rem_sh = {rem_q[31:0], quo_q[63]};
		diff   = {1'b0, rem_sh} - {2'b00, den_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= 7'd64;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 7'd1;
				if (cnt_q == 7'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath: one quotient bit a cycle
	always_ff @(posedge clk) begin
		if (req.start) begin
			quo_q <= req.num;
			rem_q <= '0;
			den_q <= req.den;
		end else if (busy_q) begin
			if (!diff[33]) begin
				rem_q <= diff[32:0];
				quo_q <= {quo_q[62:0], 1'b1};
			end else begin
				rem_q <= rem_sh;
				quo_q <= {quo_q[62:0], 1'b0};
			end
		end
	end

	assign rsp.done = done_q;
	assign rsp.quo  = quo_q;

endmodule

[rtl/autorange_resistance_meter.sv]
// ----------------------------------------------------------------------------
// autorange_resistance_meter: auto-ranging four-wire resistance meter
// Scales each in-range converter sample by reference and gain, adjusts the range
// and smooths the result over a moving window.
// ----------------------------------------------------------------------------
// Each request runs up to three serial divisions (raw, gain and mean);
// a restart fills the window instead of the mean division, a smaller
// reference fills it after the raw division alone, a non-positive sample
// skips the gain division, and an overrange answers without any division.
// One request at a time: the next is accepted once the result is taken.
// Reset: ref_count 4, references 0, top reference, gain 0, average restart.
module autorange_resistance_meter #(
	parameter int AVG_DEPTH = 10,
	parameter int MAX_REFS  = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic signed [23:0] adc_sample,
	output logic        out_valid,
	input  logic        out_ready,
	output logic signed [32:0] resistance,
	output logic        overrange,
	output logic [1:0]  ref_select,
	output logic [2:0]  gain_code,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data
);

	localparam int PW = (AVG_DEPTH > 1) ? $clog2(AVG_DEPTH) : 1;
	localparam int LimRefs = (MAX_REFS < 4) ? MAX_REFS : 4;
	localparam logic [PW-1:0] LastIdx = PW'(AVG_DEPTH - 1);

	// states
	localparam logic [3:0] StIdle  = 4'd0;
	localparam logic [3:0] StMul   = 4'd1;
	localparam logic [3:0] StDiv1  = 4'd2;
	localparam logic [3:0] StCmp   = 4'd3;
	localparam logic [3:0] StDiv2  = 4'd4;
	localparam logic [3:0] StGain  = 4'd5;
	localparam logic [3:0] StFill  = 4'd6;
	localparam logic [3:0] StSum   = 4'd7;
	localparam logic [3:0] StAvg   = 4'd8;
	localparam logic [3:0] StOut   = 4'd9;
	localparam logic [3:0] StMulS  = 4'd10;
	localparam logic [3:0] StAvgF  = 4'd11;
	localparam logic [3:0] StAvgD  = 4'd12;

	logic [3:0]  state_q;
	logic [2:0]  ref_count_q;
	logic [31:0] ref_q [4];
	logic [1:0]  cur_ref_q;
	logic [2:0]  cur_gain_q;
	logic        restart_q;
	logic [PW-1:0] ptr_q;
	logic [PW-1:0] idx_q;
	logic signed [32:0] win_q [AVG_DEPTH];
	logic signed [23:0] sample_q;
	logic [55:0] prod_s1;
	logic        neg_q;
	logic signed [32:0] raw_q;
	logic signed [32:0] winrd_q;
	logic signed [39:0] sum_q;
	logic signed [32:0] res_q;
	logic        over_q;
	logic        first_q;
	arm_pkg::div_req_t dreq;
	arm_pkg::div_rsp_t drsp;

	logic [1:0]  eff_max;
	logic [1:0]  ref_eff;
	logic [23:0] mag;
	logic signed [33:0] rawv;
	logic signed [40:0] lhs;
	logic signed [40:0] rhs;
	logic [67:0] g9;
	logic [2:0]  kgain;
	logic signed [39:0] avgv;
	logic [39:0] absum;

	// effective reference count minus one, clamped reference and sample magnitude
	always_comb begin
		if (ref_count_q == 3'd0)
			eff_max = 2'd0;
		else if (ref_count_q > 3'(LimRefs))
			eff_max = 2'(LimRefs - 1);
		else
			eff_max = 2'(ref_count_q - 3'd1);
		ref_eff = (cur_ref_q > eff_max) ? eff_max : cur_ref_q;
		mag = sample_q[23] ? 24'(-sample_q) : sample_q;
	end

	assign in_ready  = (state_q == StIdle);
	assign cfg_ready = (state_q == StIdle);

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ref_count_q <= 3'd4;
			for (int i = 0; i < 4; i++) ref_q[i] <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				arm_pkg::RegRefCount: ref_count_q <= cfg_data[2:0];
				arm_pkg::RegRef0:     ref_q[0] <= cfg_data;
				arm_pkg::RegRef1:     ref_q[1] <= cfg_data;
				arm_pkg::RegRef2:     ref_q[2] <= cfg_data;
				arm_pkg::RegRef3:     ref_q[3] <= cfg_data;
				default: ;
			endcase
		end
	end

	// saturate raw quotient with sign; range and gain compares, mean magnitude and sign
	always_comb begin
		rawv = neg_q ? -$signed({2'b00, drsp.quo[31:0]}) : $signed({2'b00, drsp.quo[31:0]});
		if (drsp.quo[63:32] != '0)
			rawv = neg_q ? -34'sd4294967296 : 34'sd4294967295;
		else if (!neg_q && rawv > 34'sd4294967295)
			rawv = 34'sd4294967295;
		lhs = 41'(raw_q) * 41'sd10;
		rhs = $signed({9'd0, ref_q[2'(ref_eff - 2'd1)]}) * 41'sd9;
		// floor(9q/10) >= 2^k exactly when 9q >= 10 * 2^k
		g9 = 68'(drsp.quo) * 68'd9;
		kgain = 3'd0;
		for (int k = 1; k < 8; k++)
			if (g9 >= (68'd10 << k)) kgain = 3'(k);
		absum = sum_q[39] ? 40'(-sum_q) : sum_q;
		avgv = sum_q[39] ? -$signed({1'b0, drsp.quo[38:0]})
		                 : $signed({1'b0, drsp.quo[38:0]});
	end

	// divider requests
	always_comb begin
		dreq.start = 1'b0;
		dreq.num   = '0;
		dreq.den   = '0;
		if (state_q == StMulS) begin
			dreq.start = 1'b1;
			dreq.num   = 64'(prod_s1);
			dreq.den   = 32'({8'd0, arm_pkg::FullScale} << cur_gain_q);
		end else if (state_q == StCmp && !(ref_eff != 2'd0 && lhs < rhs) && !sample_q[23]
		             && sample_q != '0) begin
			dreq.start = 1'b1;
			dreq.num   = 64'({8'd0, arm_pkg::FullScale} << cur_gain_q);
			dreq.den   = 32'(sample_q);
		end else if (state_q == StAvgF) begin
			dreq.start = 1'b1;
			dreq.num   = 64'(absum);
			dreq.den   = 32'(AVG_DEPTH);
		end
	end

	arm_div u_div (
		.clk(clk),
		.arst_n(arst_n),
		.req(dreq),
		.rsp(drsp)
	);

	// window memory: one entry written a cycle, read data registered
	always_ff @(posedge clk) begin
		if (state_q == StFill)
			win_q[idx_q] <= raw_q;
		else if (state_q == StGain && !first_q)
			win_q[ptr_q] <= raw_q;
		winrd_q <= win_q[idx_q];
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= StIdle;
			cur_ref_q  <= 2'(LimRefs - 1);
			cur_gain_q <= '0;
			restart_q  <= 1'b1;
			ptr_q      <= '0;
			idx_q      <= '0;
			out_valid  <= 1'b0;
			first_q    <= 1'b0;
		end else begin
			case (state_q)
				StIdle: begin
					if (in_valid) begin
						sample_q  <= adc_sample;
						cur_ref_q <= ref_eff;
						state_q   <= StMul;
					end
				end
				StMul: begin
					if (sample_q == arm_pkg::FullScale) begin
						over_q <= 1'b1;
						res_q  <= '0;
						if (cur_gain_q != '0)
							cur_gain_q <= '0;
						else if (cur_ref_q < eff_max)
							cur_ref_q <= cur_ref_q + 2'd1;
						restart_q <= 1'b1;
						out_valid <= 1'b1;
						state_q   <= StOut;
					end else begin
						over_q  <= 1'b0;
						prod_s1 <= 56'(mag) * 56'(ref_q[cur_ref_q]);
						neg_q   <= sample_q[23];
						state_q <= StMulS;
					end
				end
				StMulS: state_q <= StDiv1;
				StDiv1: begin
					if (drsp.done) begin
						raw_q   <= rawv[32:0];
						state_q <= StCmp;
					end
				end
				StCmp: begin
					if (ref_eff != 2'd0 && lhs < rhs) begin
						cur_ref_q  <= cur_ref_q - 2'd1;
						cur_gain_q <= '0;
						first_q    <= 1'b1;
						idx_q      <= '0;
						state_q    <= StFill;
					end else if (sample_q[23] || sample_q == '0) begin
						cur_gain_q <= '0;
						first_q    <= restart_q;
						state_q    <= StGain;
					end else begin
						first_q <= restart_q;
						state_q <= StDiv2;
					end
				end
				StDiv2: begin
					if (drsp.done) begin
						cur_gain_q <= kgain;
						state_q    <= StGain;
					end
				end
				StGain: begin
					idx_q <= '0;
					if (first_q) begin
						state_q <= StFill;
					end else begin
						ptr_q   <= (ptr_q == LastIdx) ? '0 : ptr_q + PW'(1);
						sum_q   <= '0;
						state_q <= StSum;
					end
				end
				StFill: begin
					idx_q <= idx_q + PW'(1);
					if (idx_q == LastIdx) begin
						ptr_q     <= '0;
						restart_q <= 1'b0;
						res_q     <= raw_q;
						out_valid <= 1'b1;
						state_q   <= StOut;
					end
				end
				StSum: begin
					// the registered read data sits between the read address and the accumulate
					idx_q <= idx_q + PW'(1);
					if (idx_q != '0)
						sum_q <= sum_q + 40'(winrd_q);
					if (idx_q == LastIdx)
						state_q <= StAvg;
				end
				// add the last entry
				StAvg: begin
					sum_q   <= sum_q + 40'(winrd_q);
					state_q <= StAvgF;
				end
				// launch the mean division
				StAvgF: state_q <= StAvgD;
				// restore the sign of the truncated mean
				StAvgD: begin
					if (drsp.done) begin
						res_q     <= avgv[32:0];
						out_valid <= 1'b1;
						state_q   <= StOut;
					end
				end
				StOut: begin
					if (out_ready) begin
						out_valid <= 1'b0;
						state_q   <= StIdle;
					end
				end
				default: state_q <= StIdle;
			endcase
		end
	end

	assign resistance = res_q;
	assign overrange  = over_q;
	assign ref_select = cur_ref_q;
	assign gain_code  = cur_gain_q;

endmodule
